>>> rtl/lppd_pkg.sv
package lppd_pkg;

	localparam int unsigned HdrBytes = 8;
	localparam int unsigned CntW     = $clog2(HdrBytes);

	// Result kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_HALT    = 3'b100
	} phase_t;

	localparam logic [31:0] MaxLenReset = 32'd134217728;

	// Configuration register indexes
	localparam logic REG_MAX_LEN = 1'b0;

	// Result payload, packed from the lowest bit up:
	// packet_type, payload_length, packet_status, data_byte
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] packet_status;
		logic [31:0] payload_length;
		logic [15:0] packet_type;
	} result_t;

endpackage

>>> rtl/length_prefixed_packet_deframer.sv
// Path: a byte that yields a result passes the input register, then the result register;
// bytes that produce no result just pass through the input register. Throughput: one byte
// per cycle while the sink keeps up, set by the single-pass parse between the two registers.
// Reset (arst_n low, asynchronous): parser returns to the header phase with an empty header,
// max_payload_len returns to 134217728, both pipeline registers empty.
module length_prefixed_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] stream_byte
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [15:0] packet_type, [47:16] payload_length,
	                               // [63:48] packet_status, [71:64] data_byte
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast,   // end_of_packet
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ------------------------------------------------------------------
	// Configuration register: max_payload_len at byte addresses 0 to 3 (paddr[2] low).
	// Addresses 4 to 7 ignore writes and read back zero.
	// ------------------------------------------------------------------
	logic [31:0] max_len_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lppd_pkg::REG_MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lppd_pkg::MaxLenReset;
		end else if (cfg_wr) begin
			max_len_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == lppd_pkg::REG_MAX_LEN) ? max_len_q : 32'd0;

	// ------------------------------------------------------------------
	// Stage 1: input register. The stage moves on whenever the result
	// register is empty or its transaction completes this cycle, so a new
	// byte is taken every cycle as long as the sink keeps up.
	// ------------------------------------------------------------------
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       fire_s1;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || adv;
	assign fire_s1  = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// ------------------------------------------------------------------
	// Parser state
	// ------------------------------------------------------------------
	lppd_pkg::phase_t             phase_q, phase_d;
	logic [lppd_pkg::CntW-1:0]    cnt_q, cnt_d;
	logic [55:0]                  cap_q;       // header bytes 0..6; byte 7 arrives live
	logic [31:0]                  rem_q, rem_d;

	logic                         produce;
	lppd_pkg::kind_t              kind_d;
	lppd_pkg::result_t            res_d;
	logic                         last_d;

	logic [15:0]                  hdr_type;
	logic [31:0]                  hdr_len;
	logic [15:0]                  hdr_status;
	logic                         hdr_done;

	assign hdr_type   = cap_q[15:0];
	assign hdr_len    = cap_q[47:16];
	assign hdr_status = {byte_s1, cap_q[55:48]};
	assign hdr_done   = (cnt_q == lppd_pkg::CntW'(lppd_pkg::HdrBytes - 1));

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		produce = 1'b0;
		kind_d  = lppd_pkg::KIND_HEADER;
		res_d   = '0;
		last_d  = 1'b0;
		unique case (phase_q)
			lppd_pkg::PH_HEADER: begin
				if (!hdr_done) begin
					// collect one more header byte
					cnt_d = cnt_q + 1'b1;
				end else begin
					cnt_d   = '0;
					produce = 1'b1;
					if (hdr_len > max_len_q) begin
						// implausible length: report and halt for good
						phase_d              = lppd_pkg::PH_HALT;
						kind_d               = lppd_pkg::KIND_ERROR;
						res_d.payload_length = hdr_len;
					end else begin
						kind_d               = lppd_pkg::KIND_HEADER;
						res_d.packet_type    = hdr_type;
						res_d.payload_length = hdr_len;
						res_d.packet_status  = hdr_status;
						if (hdr_len == 32'd0) begin
							// empty packet ends with its header
							last_d = 1'b1;
						end else begin
							phase_d = lppd_pkg::PH_PAYLOAD;
							rem_d   = hdr_len;
						end
					end
				end
			end
			lppd_pkg::PH_PAYLOAD: begin
				produce         = 1'b1;
				kind_d          = lppd_pkg::KIND_PAYLOAD;
				res_d.data_byte = byte_s1;
				rem_d           = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					last_d  = 1'b1;
					phase_d = lppd_pkg::PH_HEADER;
				end
			end
			lppd_pkg::PH_HALT: begin
				// drop every byte
			end
			default: begin
				phase_d = lppd_pkg::PH_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lppd_pkg::PH_HEADER;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
		end
	end

	// Header bytes land at their own lane; each header rewrites all of them.
	always_ff @(posedge clk) begin
		if (fire_s1 && (phase_q == lppd_pkg::PH_HEADER) && !hdr_done) begin
			cap_q[8*cnt_q +: 8] <= byte_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: result register, holds the transaction until the sink takes it
	// ------------------------------------------------------------------
	logic              m_valid_s2;
	lppd_pkg::result_t res_s2;
	lppd_pkg::kind_t   kind_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (adv) begin
			m_valid_s2 <= fire_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			res_s2  <= res_d;
			kind_s2 <= kind_d;
			last_s2 <= last_d;
		end
	end

	assign m_tvalid = m_valid_s2;
	assign m_tdata  = res_s2;
	assign m_tuser  = kind_s2;
	assign m_tlast  = last_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && phase_q == lppd_pkg::PH_HALT) |=> !m_tvalid)
		else $error("result produced while halted");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && produce && kind_d == lppd_pkg::KIND_ERROR) |=>
		(phase_q == lppd_pkg::PH_HALT))
		else $error("length error did not halt the parser");

	a_error_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == lppd_pkg::KIND_ERROR) |-> !m_tlast)
		else $error("error result marked last");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lppd_pkg::PH_PAYLOAD) |-> (rem_q != 32'd0))
		else $error("payload phase with nothing left to pass on");

	a_header_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && phase_q == lppd_pkg::PH_PAYLOAD) |=> (cnt_q == '0))
		else $error("header count not cleared during payload");

endmodule
